FILE: rtl/qsu_pkg.sv
// Package for the quoted-string unescaper: types, character codes and
// per-byte helper functions. No dependencies.
package qsu_pkg;

  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned PTR_W      = $clog2(FIFO_DEPTH);
  localparam int unsigned CNT_W      = $clog2(FIFO_DEPTH + 1);

  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_0      = 8'h30;
  localparam logic [7:0] CH_7      = 8'h37;
  localparam logic [7:0] CH_9      = 8'h39;
  localparam logic [7:0] CH_LA     = 8'h61;
  localparam logic [7:0] CH_LF_A   = 8'h66;
  localparam logic [7:0] CH_UA     = 8'h41;
  localparam logic [7:0] CH_UF     = 8'h46;
  localparam logic [7:0] CH_X      = 8'h78;
  localparam logic [7:0] CH_T      = 8'h74;
  localparam logic [7:0] CH_N      = 8'h6E;
  localparam logic [7:0] CH_F      = 8'h66;
  localparam logic [7:0] CH_R      = 8'h72;
  localparam logic [7:0] CH_V      = 8'h76;
  localparam logic [7:0] CH_B      = 8'h62;
  localparam logic [7:0] CH_A      = 8'h61;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_FF     = 8'h0C;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_VT     = 8'h0B;
  localparam logic [7:0] CH_BS     = 8'h08;
  localparam logic [7:0] CH_BEL    = 8'h07;

  typedef enum logic [2:0] {
    PH_IDLE  = 3'd0,
    PH_BODY  = 3'd1,
    PH_ESC   = 3'd2,
    PH_SQESC = 3'd3,
    PH_HEX1  = 3'd4,
    PH_HEX2  = 3'd5,
    PH_OCT2  = 3'd6,
    PH_OCT3  = 3'd7
  } phase_t;

  typedef enum logic [1:0] {
    KIND_BYTE   = 2'd0,
    KIND_CLOSED = 2'd1,
    KIND_UNTERM = 2'd2
  } kind_t;

  typedef struct packed {
    logic [7:0] out_byte;
    kind_t      kind;
    logic       last;
  } res_t;

  typedef struct packed {
    logic   emit;
    res_t   res;
    phase_t phase;
  } body_t;

  typedef struct packed {
    logic [1:0] n;
    res_t       r0;
    res_t       r1;
    phase_t     phase_next;
    logic [7:0] quote_next;
    logic [7:0] esc_next;
  } dec_t;

  function automatic res_t mk_res(logic [7:0] b, kind_t k);
    res_t r;
    r.out_byte = (k == KIND_BYTE) ? b : 8'h00;
    r.kind     = k;
    r.last     = (k != KIND_BYTE);
    return r;
  endfunction

  // bit 4 = valid, bits 3:0 = digit value
  function automatic logic [4:0] hex_digit(logic [7:0] b);
    logic [7:0] t;
    logic [4:0] h;
    t = 8'h00;
    h = 5'd0;
    if (b >= CH_0 && b <= CH_9) begin
      t = b - CH_0;
      h = {1'b1, t[3:0]};
    end else if (b >= CH_LA && b <= CH_LF_A) begin
      t = b - CH_LA + 8'd10;
      h = {1'b1, t[3:0]};
    end else if (b >= CH_UA && b <= CH_UF) begin
      t = b - CH_UA + 8'd10;
      h = {1'b1, t[3:0]};
    end
    return h;
  endfunction

  function automatic logic is_octal(logic [7:0] b);
    return (b >= CH_0) && (b <= CH_7);
  endfunction

  // Ordinary byte of the string body.
  function automatic body_t body_byte(logic [7:0] b, logic [7:0] q);
    body_t o;
    o.emit  = 1'b1;
    o.res   = mk_res(b, KIND_BYTE);
    o.phase = PH_BODY;
    if (b == q) begin
      o.res   = mk_res(8'h00, KIND_CLOSED);
      o.phase = PH_IDLE;
    end else if (b == CH_NUL) begin
      o.res   = mk_res(8'h00, KIND_UNTERM);
      o.phase = PH_IDLE;
    end else if (b == CH_BSLASH) begin
      o.emit  = 1'b0;
      o.phase = (q == CH_SQUOTE) ? PH_SQESC : PH_ESC;
    end
    return o;
  endfunction

endpackage

FILE: rtl/qsu_decode.sv
// Per-byte decode step: current escape state plus one source byte gives
// the next state and up to two results. Depends on qsu_pkg.
module qsu_decode import qsu_pkg::*; (
  input  phase_t     phase,
  input  logic [7:0] quote_char,
  input  logic [7:0] escape_value,
  input  logic [7:0] data_byte,
  input  logic       start_req,
  output dec_t       dec
);

  body_t      bb;
  logic [4:0] hx;
  logic [7:0] oct_d;
  logic [7:0] ev_sh3;

  assign bb     = body_byte(data_byte, quote_char);
  assign hx     = hex_digit(data_byte);
  assign oct_d  = data_byte - CH_0;
  assign ev_sh3 = {escape_value[4:0], 3'b000};

  // on a byte that ends an escape early: emits a leading result r0, then the byte handled as body
  always_comb begin
    dec.n          = 2'd0;
    dec.r0         = mk_res(8'h00, KIND_BYTE);
    dec.r1         = mk_res(8'h00, KIND_BYTE);
    dec.phase_next = phase;
    dec.quote_next = quote_char;
    dec.esc_next   = escape_value;
    if (start_req) begin
      dec.quote_next = data_byte;
      dec.esc_next   = 8'h00;
      dec.phase_next = PH_BODY;
    end else begin
      case (phase)
        PH_BODY: begin
          dec.n          = {1'b0, bb.emit};
          dec.r0         = bb.res;
          dec.phase_next = bb.phase;
        end
        PH_ESC: begin
          dec.n          = 2'd1;
          dec.phase_next = PH_BODY;
          dec.r0         = mk_res(data_byte, KIND_BYTE);
          case (data_byte)
            CH_NUL: begin
              dec.r0         = mk_res(8'h00, KIND_UNTERM);
              dec.phase_next = PH_IDLE;
            end
            CH_LF:  dec.n = 2'd0;
            CH_T:   dec.r0 = mk_res(CH_TAB, KIND_BYTE);
            CH_N:   dec.r0 = mk_res(CH_NL, KIND_BYTE);
            CH_F:   dec.r0 = mk_res(CH_FF, KIND_BYTE);
            CH_R:   dec.r0 = mk_res(CH_CR, KIND_BYTE);
            CH_V:   dec.r0 = mk_res(CH_VT, KIND_BYTE);
            CH_B:   dec.r0 = mk_res(CH_BS, KIND_BYTE);
            CH_A:   dec.r0 = mk_res(CH_BEL, KIND_BYTE);
            CH_X: begin
              dec.n          = 2'd0;
              dec.phase_next = PH_HEX1;
            end
            default: begin
              if (is_octal(data_byte)) begin
                dec.n          = 2'd0;
                dec.esc_next   = oct_d;
                dec.phase_next = PH_OCT2;
              end
            end
          endcase
        end
        PH_SQESC: begin
          if (data_byte == CH_BSLASH || data_byte == CH_SQUOTE || data_byte == CH_HASH) begin
            dec.n          = 2'd1;
            dec.r0         = mk_res(data_byte, KIND_BYTE);
            dec.phase_next = PH_BODY;
          end else begin
            dec.n          = {bb.emit, ~bb.emit};
            dec.r0         = mk_res(CH_BSLASH, KIND_BYTE);
            dec.r1         = bb.res;
            dec.phase_next = bb.phase;
          end
        end
        PH_HEX1: begin
          if (hx[4]) begin
            dec.esc_next   = {4'h0, hx[3:0]};
            dec.phase_next = PH_HEX2;
          end else begin
            dec.n          = {bb.emit, ~bb.emit};
            dec.r0         = mk_res(CH_X, KIND_BYTE);
            dec.r1         = bb.res;
            dec.phase_next = bb.phase;
          end
        end
        PH_HEX2: begin
          if (hx[4]) begin
            dec.n          = 2'd1;
            dec.r0         = mk_res({escape_value[3:0], hx[3:0]}, KIND_BYTE);
            dec.phase_next = PH_BODY;
          end else begin
            dec.n          = {bb.emit, ~bb.emit};
            dec.r0         = mk_res(escape_value, KIND_BYTE);
            dec.r1         = bb.res;
            dec.phase_next = bb.phase;
          end
        end
        PH_OCT2: begin
          if (is_octal(data_byte)) begin
            dec.esc_next   = ev_sh3 + oct_d;
            dec.phase_next = PH_OCT3;
          end else begin
            dec.n          = {bb.emit, ~bb.emit};
            dec.r0         = mk_res(escape_value, KIND_BYTE);
            dec.r1         = bb.res;
            dec.phase_next = bb.phase;
          end
        end
        PH_OCT3: begin
          if (is_octal(data_byte) && escape_value[7:5] == 3'b000) begin
            dec.n          = 2'd1;
            dec.r0         = mk_res(ev_sh3 + oct_d, KIND_BYTE);
            dec.phase_next = PH_BODY;
          end else begin
            dec.n          = {bb.emit, ~bb.emit};
            dec.r0         = mk_res(escape_value, KIND_BYTE);
            dec.r1         = bb.res;
            dec.phase_next = bb.phase;
          end
        end
        default: dec.phase_next = PH_IDLE;
      endcase
    end
  end

endmodule

FILE: rtl/qsu_out_fifo.sv
// Result queue: takes zero, one or two results per cycle, hands out one.
// Depends on qsu_pkg.
module qsu_out_fifo import qsu_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic [1:0]       push_n,
  input  res_t             push0,
  input  res_t             push1,
  output logic             room2,
  output logic             valid,
  input  logic             pop,
  output res_t             head
);

  res_t             mem [FIFO_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic [PTR_W-1:0] wr_ptr1;

  assign wr_ptr1 = wr_ptr + PTR_W'(1);
  assign valid   = (count != '0);
  assign room2   = (count <= CNT_W'(FIFO_DEPTH - 2));
  assign head    = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push_n != 2'd0) begin
      mem[wr_ptr] <= push0;
    end
    if (push_n == 2'd2) begin
      mem[wr_ptr1] <= push1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + PTR_W'(push_n);
      if (pop) begin
        rd_ptr <= rd_ptr + PTR_W'(1);
      end
      count <= count + CNT_W'(push_n) - CNT_W'(pop);
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(FIFO_DEPTH))
    else $error("result queue overflow");

  a_count_track: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> count == $past(count) + CNT_W'($past(push_n)) - CNT_W'($past(pop)))
    else $error("result queue count mismatch");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> count != '0)
    else $error("pop from empty result queue");

endmodule

FILE: rtl/quoted_string_unescaper_core.sv
// Top level of the quoted-string unescaper: input register, escape state,
// decode step and result queue. Depends on qsu_pkg, qsu_decode, qsu_out_fifo.
// Path: each source byte is held in the input register, decoded and written to the result
// queue, whose head drives the output. One byte per cycle while the queue holds at most two
// results; when it holds more, input stalls until the output drains it, whatever the byte.
// Reset (rst, synchronous): state idle, quote and escape value zero, queue empty.
module quoted_string_unescaper_core import qsu_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // [7:0] data_byte
  input  logic       s_tuser,   // [0] start_req
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,   // [7:0] out_byte
  output logic [1:0] m_tuser,   // [1:0] result_kind
  output logic       m_tlast
);

  logic       in_valid;
  logic [7:0] in_byte;
  logic       in_start;
  phase_t     phase;
  logic [7:0] quote_char;
  logic [7:0] escape_value;
  dec_t       dec;
  logic       room2;
  logic       advance;
  logic       pop;
  res_t       head;

  assign advance  = in_valid && room2;
  assign s_tready = !in_valid || advance;
  assign pop      = m_tvalid && m_tready;
  assign m_tdata  = head.out_byte;
  assign m_tuser  = head.kind;
  assign m_tlast  = head.last;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_byte  <= s_tdata;
      in_start <= s_tuser;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_IDLE;
      quote_char   <= 8'h00;
      escape_value <= 8'h00;
    end else if (advance) begin
      phase        <= dec.phase_next;
      quote_char   <= dec.quote_next;
      escape_value <= dec.esc_next;
    end
  end

  qsu_decode u_decode (
    .phase        (phase),
    .quote_char   (quote_char),
    .escape_value (escape_value),
    .data_byte    (in_byte),
    .start_req    (in_start),
    .dec          (dec)
  );

  qsu_out_fifo u_fifo (
    .clk    (clk),
    .rst    (rst),
    .push_n (advance ? dec.n : 2'd0),
    .push0  (dec.r0),
    .push1  (dec.r1),
    .room2  (room2),
    .valid  (m_tvalid),
    .pop    (pop),
    .head   (head)
  );

  a_pair_first_byte: assert property (@(posedge clk) disable iff (rst)
    (advance && dec.n == 2'd2) |-> dec.r0.kind == KIND_BYTE)
    else $error("first of two results is not a data byte");

  a_start_opens: assert property (@(posedge clk) disable iff (rst)
    (advance && in_start) |=> (phase == PH_BODY && quote_char == $past(in_byte)))
    else $error("start byte did not open a string");

  a_end_goes_idle: assert property (@(posedge clk) disable iff (rst)
    (advance && !in_start && dec.n != 2'd0 &&
     (dec.n == 2'd2 ? dec.r1.last : dec.r0.last)) |=> phase == PH_IDLE)
    else $error("string end did not return to idle");

endmodule

FILE: tb/sv/qsu_stream_checker.sv
`timescale 1ns / 100ps
// Stream checker for quoted_string_unescaper_core: decodes every accepted source byte
// with its own escape state machine and compares each output transfer in order.
// Depends on qsu_pkg for the result kinds, the phase encoding and the character codes.
module qsu_stream_checker import qsu_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  input  logic       s_tready,
  input  logic [7:0] s_tdata,
  input  logic       s_tuser,
  input  logic       m_tvalid,
  input  logic       m_tready,
  input  logic [7:0] m_tdata,
  input  logic [1:0] m_tuser,
  input  logic       m_tlast,
  output int         errors,
  output int         pending,
  output int         results_seen
);

  phase_t     scan_phase;
  logic [7:0] open_quote;
  logic [7:0] esc_acc;
  res_t       decoded_q[$];

  function automatic void push_decoded(logic [7:0] b, kind_t k);
    res_t r;
    r.out_byte = (k == KIND_BYTE) ? b : 8'h00;
    r.kind     = k;
    r.last     = (k != KIND_BYTE);
    decoded_q.push_back(r);
  endfunction

  function automatic int hex_value(logic [7:0] b);
    if (b >= CH_0 && b <= CH_9) return int'(b - CH_0);
    if (b >= CH_LA && b <= CH_LF_A) return int'(b - CH_LA) + 10;
    if (b >= CH_UA && b <= CH_UF) return int'(b - CH_UA) + 10;
    return -1;
  endfunction

  function automatic logic octal_digit(logic [7:0] b);
    return (b >= CH_0) && (b <= CH_7);
  endfunction

  function automatic void take_body(logic [7:0] b);
    if (b == open_quote) begin
      scan_phase = PH_IDLE;
      push_decoded(8'h00, KIND_CLOSED);
    end else if (b == CH_NUL) begin
      scan_phase = PH_IDLE;
      push_decoded(8'h00, KIND_UNTERM);
    end else if (b == CH_BSLASH) begin
      scan_phase = (open_quote == CH_SQUOTE) ? PH_SQESC : PH_ESC;
    end else begin
      scan_phase = PH_BODY;
      push_decoded(b, KIND_BYTE);
    end
  endfunction

  function automatic void take_c_escape(logic [7:0] b);
    scan_phase = PH_BODY;
    case (b)
      CH_NUL: begin
        scan_phase = PH_IDLE;
        push_decoded(8'h00, KIND_UNTERM);
      end
      CH_LF: ;
      CH_T: push_decoded(CH_TAB, KIND_BYTE);
      CH_N: push_decoded(CH_NL, KIND_BYTE);
      CH_F: push_decoded(CH_FF, KIND_BYTE);
      CH_R: push_decoded(CH_CR, KIND_BYTE);
      CH_V: push_decoded(CH_VT, KIND_BYTE);
      CH_B: push_decoded(CH_BS, KIND_BYTE);
      CH_A: push_decoded(CH_BEL, KIND_BYTE);
      CH_X: scan_phase = PH_HEX1;
      default: begin
        if (octal_digit(b)) begin
          esc_acc    = {5'd0, b[2:0]};
          scan_phase = PH_OCT2;
        end else begin
          push_decoded(b, KIND_BYTE);
        end
      end
    endcase
  endfunction

  function automatic void decode_source_byte(logic [7:0] b, logic start);
    int d;
    d = hex_value(b);
    if (start) begin
      open_quote = b;
      esc_acc    = 8'h00;
      scan_phase = PH_BODY;
      return;
    end
    case (scan_phase)
      PH_BODY: take_body(b);
      PH_ESC:  take_c_escape(b);
      PH_SQESC: begin
        if (b == CH_BSLASH || b == CH_SQUOTE || b == CH_HASH) begin
          scan_phase = PH_BODY;
          push_decoded(b, KIND_BYTE);
        end else begin
          push_decoded(CH_BSLASH, KIND_BYTE);
          take_body(b);
        end
      end
      PH_HEX1: begin
        if (d >= 0) begin
          esc_acc    = 8'(d);
          scan_phase = PH_HEX2;
        end else begin
          push_decoded(CH_X, KIND_BYTE);
          take_body(b);
        end
      end
      PH_HEX2: begin
        if (d >= 0) begin
          scan_phase = PH_BODY;
          push_decoded({esc_acc[3:0], 4'(d)}, KIND_BYTE);
        end else begin
          push_decoded(esc_acc, KIND_BYTE);
          take_body(b);
        end
      end
      PH_OCT2: begin
        if (octal_digit(b)) begin
          esc_acc    = {2'd0, esc_acc[2:0], b[2:0]};
          scan_phase = PH_OCT3;
        end else begin
          push_decoded(esc_acc, KIND_BYTE);
          take_body(b);
        end
      end
      PH_OCT3: begin
        // third digit only while the value still fits a byte
        if (octal_digit(b) && esc_acc < 8'd32) begin
          scan_phase = PH_BODY;
          push_decoded({esc_acc[4:0], b[2:0]}, KIND_BYTE);
        end else begin
          push_decoded(esc_acc, KIND_BYTE);
          take_body(b);
        end
      end
      default: scan_phase = PH_IDLE;
    endcase
  endfunction

  task automatic flag_error(string what, res_t want);
    errors++;
    if (errors <= 10)
      $display("[%0t] %s: expected byte=%02h kind=%0d last=%0b, got byte=%02h kind=%0d last=%0b",
               $time, what, want.out_byte, want.kind, want.last, m_tdata, m_tuser, m_tlast);
  endtask

  initial begin
    errors       = 0;
    pending      = 0;
    results_seen = 0;
  end

  always @(posedge clk) begin
    res_t want;
    if (rst) begin
      scan_phase = PH_IDLE;
      open_quote = 8'h00;
      esc_acc    = 8'h00;
      decoded_q.delete();
    end else begin
      if (s_tvalid && s_tready)
        decode_source_byte(s_tdata, s_tuser);
      if (m_tvalid && m_tready) begin
        results_seen++;
        if (decoded_q.size() == 0) begin
          want = '0;
          flag_error("unexpected transfer", want);
        end else begin
          want = decoded_q.pop_front();
          if (m_tdata !== want.out_byte || m_tuser !== want.kind || m_tlast !== want.last)
            flag_error("mismatch", want);
        end
      end
    end
    pending = decoded_q.size();
  end

endmodule

FILE: tb/sv/tb_quoted_string_unescaper_core.sv
`timescale 1ns / 100ps
// Top of the quoted_string_unescaper_core testbench: clock, reset, source byte stimulus
// and output back-pressure. Depends on qsu_pkg, the core RTL and qsu_stream_checker.
module tb_quoted_string_unescaper_core;
  import qsu_pkg::*;

  typedef enum int {RX_OPEN, RX_HALF, RX_SPARSE, RX_MOSTLY} rx_mode_t;

  localparam int         SOURCE_TARGET = 1700;
  localparam logic [7:0] CH_DQUOTE     = 8'h22;
  localparam logic       START         = 1'b1;
  localparam logic       BODY          = 1'b0;

  logic       clk      = 1'b0;
  logic       rst      = 1'b1;
  logic       s_tvalid = 1'b0;
  logic       s_tready;
  logic [7:0] s_tdata  = 8'h00;
  logic       s_tuser  = 1'b0;
  logic       m_tvalid;
  logic       m_tready = 1'b0;
  logic [7:0] m_tdata;
  logic [1:0] m_tuser;
  logic       m_tlast;
  logic       hold_req = 1'b0;

  int errors, pending, results_seen;
  int burst_left  = 0;
  bit gaps_on     = 1'b1;
  int src_items   = 0;
  int num_strings = 0;

  rx_mode_t rx_mode;
  int       rx_left, hold_left;
  bit       hold_seen;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  quoted_string_unescaper_core dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .m_tlast(m_tlast)
  );

  qsu_stream_checker u_checker (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .m_tlast(m_tlast),
    .errors(errors), .pending(pending), .results_seen(results_seen)
  );

  // receiver: back-pressure in random modes, plus one long hold-off on request
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
      rx_left   = 0;
      hold_left = 0;
      hold_seen = 1'b0;
    end else if (hold_left > 0) begin
      m_tready <= 1'b0;
      hold_left--;
    end else if (hold_req && !hold_seen) begin
      hold_seen = 1'b1;
      hold_left = 300;
      m_tready <= 1'b0;
    end else begin
      if (rx_left == 0) begin
        rx_mode = rx_mode_t'($urandom_range(0, 3));
        rx_left = $urandom_range(16, 96);
      end
      rx_left--;
      case (rx_mode)
        RX_OPEN:   m_tready <= 1'b1;
        RX_HALF:   m_tready <= ($urandom_range(0, 1) == 1);
        RX_SPARSE: m_tready <= ($urandom_range(0, 3) == 0);
        default:   m_tready <= ($urandom_range(0, 7) != 0);
      endcase
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic start);
    if (gaps_on && burst_left == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(60, 200)
                                               : $urandom_range(1, 12);
    end
    if (burst_left > 0) burst_left--;
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tuser  <= start;
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic src_byte(input logic [7:0] b, input logic start);
    send_byte(b, start);
    src_items++;
  endtask

  function automatic logic [7:0] plain_char(logic [7:0] q);
    logic [7:0] b;
    do b = 8'($urandom_range(8'h20, 8'h7E)); while (b == q || b == CH_BSLASH);
    return b;
  endfunction

  function automatic logic [7:0] hex_char();
    string digits;
    digits = "0123456789abcdefABCDEF";
    return digits[$urandom_range(0, 21)];
  endfunction

  function automatic logic [7:0] oct_char();
    return CH_0 + 8'($urandom_range(0, 7));
  endfunction

  // one body element: plain byte, noise byte or an escape sequence
  task automatic send_piece(input logic [7:0] q);
    string letters;
    int    pick;
    letters = "tnfrvba";
    pick = $urandom_range(0, 99);
    if (pick < 45) begin
      src_byte(plain_char(q), BODY);
    end else if (pick < 50) begin
      src_byte(8'($urandom_range(0, 255)), BODY);
    end else begin
      src_byte(CH_BSLASH, BODY);
      if (q == CH_SQUOTE) begin
        case ($urandom_range(0, 4))
          0: src_byte(CH_BSLASH, BODY);
          1: src_byte(CH_SQUOTE, BODY);
          2: src_byte(CH_HASH, BODY);
          3: src_byte(plain_char(q), BODY);
          default: src_byte(8'($urandom_range(0, 255)), BODY);
        endcase
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 20) begin
          src_byte(letters[$urandom_range(0, 6)], BODY);
        end else if (pick < 35) begin
          src_byte(CH_X, BODY);
          src_byte(hex_char(), BODY);
          src_byte(hex_char(), BODY);
        end else if (pick < 42) begin
          src_byte(CH_X, BODY);
          src_byte(hex_char(), BODY);
        end else if (pick < 48) begin
          src_byte(CH_X, BODY);
          src_byte(plain_char(q), BODY);
        end else if (pick < 55) begin
          src_byte(oct_char(), BODY);
        end else if (pick < 62) begin
          src_byte(oct_char(), BODY);
          src_byte(oct_char(), BODY);
        end else if (pick < 80) begin
          src_byte(oct_char(), BODY);
          src_byte(oct_char(), BODY);
          src_byte(oct_char(), BODY);
        end else if (pick < 87) begin
          src_byte(CH_LF, BODY);
        end else if (pick < 89) begin
          src_byte(CH_NUL, BODY);
        end else begin
          src_byte(8'($urandom_range(0, 255)), BODY);
        end
      end
    end
  endtask

  task automatic send_string();
    logic [7:0] q;
    int         pick;
    int         len;
    pick = $urandom_range(0, 99);
    if (pick < 45)      q = CH_DQUOTE;
    else if (pick < 75) q = CH_SQUOTE;
    else                q = 8'($urandom_range(0, 255));
    num_strings++;
    src_byte(q, START);
    len = ($urandom_range(0, 15) == 0) ? $urandom_range(20, 40) : $urandom_range(0, 10);
    repeat (len) send_piece(q);
    pick = $urandom_range(0, 99);
    if (pick < 80)      src_byte(q, BODY);
    else if (pick < 90) src_byte(CH_NUL, BODY);
    // otherwise left open: the next opening quote cuts it off
    if ($urandom_range(0, 9) == 0)
      repeat ($urandom_range(1, 3)) send_byte(8'($urandom_range(0, 255)), BODY);
  endtask

  initial begin
    logic [8:0] directed_seq[$];
    int         mark;
    bit         hold_done, pause_done;
    hold_done  = 1'b0;
    pause_done = 1'b0;
    directed_seq = '{
      {BODY, CH_NUL}, {BODY, 8'hFF},                           // ignored while idle
      {START, CH_DQUOTE}, {BODY, 8'hFF},
      {BODY, CH_BSLASH}, {BODY, CH_X}, {BODY, "A"}, {BODY, "f"},
      {BODY, CH_BSLASH}, {BODY, CH_X}, {BODY, "g"},
      {BODY, CH_BSLASH}, {BODY, "3"}, {BODY, "7"}, {BODY, "7"},
      {BODY, CH_BSLASH}, {BODY, "4"}, {BODY, "0"}, {BODY, "0"},
      {BODY, CH_BSLASH}, {BODY, CH_LF},
      {BODY, CH_BSLASH}, {START, CH_SQUOTE},                   // pending escape dropped
      {BODY, CH_BSLASH}, {BODY, "q"},
      {BODY, CH_BSLASH}, {BODY, CH_HASH}, {BODY, CH_SQUOTE},
      {START, CH_DQUOTE}, {BODY, CH_BSLASH}, {BODY, CH_NUL},
      {START, CH_NUL}, {BODY, "a"}, {BODY, CH_NUL}             // zero as the quote
    };
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_seq[i]) src_byte(directed_seq[i][7:0], directed_seq[i][8]);

    while (src_items < SOURCE_TARGET) begin
      send_string();
      if (!hold_done && src_items > 500) begin
        // output held off while the source keeps streaming
        hold_req <= 1'b1;
        gaps_on   = 1'b0;
        mark      = src_items;
        while (src_items < mark + 80) send_string();
        hold_req <= 1'b0;
        gaps_on   = 1'b1;
        hold_done = 1'b1;
      end
      if (!pause_done && src_items > 1000) begin
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (4) @(posedge clk);
        pause_done = 1'b1;
      end
    end

    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("Run covered %0d source bytes in %0d random strings plus directed escapes,",
             src_items, num_strings);
    $display("with %0d decoded results checked under back-pressure and one long hold-off.",
             results_seen);
    if (errors == 0 && pending == 0) begin
      $display("TB_OK");
    end else begin
      $display("%0d errors, %0d results still due", errors, pending);
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #1_000_000;
    $display("timeout with %0d results still due", pending);
    $display("TB_ERROR");
    $finish;
  end

endmodule
